[hw/rtl/dept_pkg.sv]
package dept_pkg;

  localparam int MAX_SYMBOLS = 65536;
  localparam int ALPHABET    = 26;
  localparam int NODE_CAP    = MAX_SYMBOLS + 2;
  localparam int BUF_CAP     = 2 * MAX_SYMBOLS + 2;
  localparam int MIDDLE      = MAX_SYMBOLS + 1;
  localparam int SW          = 5;
  localparam int NW          = $clog2(NODE_CAP);
  localparam int PW          = $clog2(BUF_CAP);
  localparam int CW          = $clog2(NODE_CAP * ALPHABET);
  localparam int NDW         = PW + NW;
  localparam int PARW        = NW + SW;

  typedef logic [NW-1:0] node_t;
  typedef logic [PW-1:0] pos_t;
  typedef logic signed [PW-1:0] len_t;
  typedef logic [CW-1:0] cidx_t;
  typedef logic [SW-1:0] sym_t;

  function automatic cidx_t child_index(node_t n, sym_t s);
    cidx_t m;
    m = CW'(n) * CW'(ALPHABET);
    return m + CW'(s);
  endfunction

endpackage

[hw/rtl/double_ended_palindrome_tree_core.sv]
// Channel  Ports                                         Direction
// in       in_valid, in_stall, in_action, in_symbol      item into the block
// out      out_valid, out_stall, out_end_palindromes,     item out of the block
//          out_distinct_palindromes, out_running_total, out_overflow
// Each item walks the suffix links from the node at the growing end. A node creation
// adds a second walk for the new node's link before the node is written; an existing
// palindrome reads its length and depth. Outside the string a link step reads no symbol.
// The rate is set by the link walk, one node memory read and one symbol read per step.
// Reset is synchronous and needs no clearing pass:
// child entries are checked against the parent and letter stored with each node.
// The block takes no new item until the result has been taken.
module double_ended_palindrome_tree_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [4:0]  in_symbol,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_end_palindromes,
  output logic [16:0] out_distinct_palindromes,
  output logic [31:0] out_running_total,
  output logic        out_overflow
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WRD  = 4'd1;
  localparam logic [3:0] S_WLEN = 4'd2;
  localparam logic [3:0] S_WCMP = 4'd3;
  localparam logic [3:0] S_CRD  = 4'd4;
  localparam logic [3:0] S_CCHK = 4'd5;
  localparam logic [3:0] S_LRD  = 4'd6;
  localparam logic [3:0] S_LCHK = 4'd7;
  localparam logic [3:0] S_LDEP = 4'd8;
  localparam logic [3:0] S_FRD  = 4'd9;
  localparam logic [3:0] S_FGET = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  localparam int NW = dept_pkg::NW;
  localparam int PW = dept_pkg::PW;

  logic [3:0]       state_r, state_nxt;
  dept_pkg::pos_t   front_r, front_nxt, back_r, back_nxt;
  dept_pkg::node_t  fnode_r, fnode_nxt, bnode_r, bnode_nxt;
  dept_pkg::node_t  ntot_r, ntot_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic             at_back_r, at_back_nxt, phase_r, phase_nxt;
  dept_pkg::sym_t   sym_r, sym_nxt;
  dept_pkg::node_t  x_r, x_nxt, cur_r, cur_nxt, cur_link_r, cur_link_nxt;
  dept_pkg::node_t  link_r, link_nxt, c_r, c_nxt;
  dept_pkg::len_t   len_r, len_nxt, cur_len_r, cur_len_nxt, fin_len_r, fin_len_nxt;
  logic [NW-1:0]    fin_dep_r, fin_dep_nxt;
  dept_pkg::cidx_t  idx_r, idx_nxt;
  logic [16:0]      o_end_r, o_end_nxt, o_dist_r, o_dist_nxt;
  logic [31:0]      o_tot_r, o_tot_nxt;
  logic             o_ovf_r, o_ovf_nxt;

  logic                         sym_we;
  dept_pkg::pos_t               sym_wa, sym_ra;
  dept_pkg::sym_t               sym_rd;
  logic                         node_we;
  dept_pkg::node_t              node_wa, node_ra, node_ra_r;
  logic [dept_pkg::NDW-1:0]     node_wd, node_raw;
  logic                         dep_we;
  dept_pkg::node_t              dep_wa, dep_ra, dep_ra_r;
  logic [NW-1:0]                dep_wd, dep_raw, dep_rd;
  logic                         par_we;
  dept_pkg::node_t              par_wa, par_ra;
  logic [dept_pkg::PARW-1:0]    par_wd, par_rd;
  logic                         child_we;
  dept_pkg::cidx_t              child_wa, child_ra;
  dept_pkg::node_t              child_wd, child_rd;

  dept_pkg::len_t               nd_len;
  dept_pkg::node_t              nd_link;
  logic signed [PW+1:0]         ps;
  logic                         inspan;
  dept_pkg::pos_t               cnt;
  logic                         c_valid;
  dept_pkg::node_t              guard_c;

  dept_ram #(.W(dept_pkg::SW), .D(dept_pkg::BUF_CAP)) u_sym (
    .clk(clk), .we(sym_we), .waddr(sym_wa), .wdata(in_symbol),
    .raddr(sym_ra), .rdata(sym_rd));
  dept_ram #(.W(dept_pkg::NDW), .D(dept_pkg::NODE_CAP)) u_node (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_raw));
  dept_ram #(.W(NW), .D(dept_pkg::NODE_CAP)) u_dep (
    .clk(clk), .we(dep_we), .waddr(dep_wa), .wdata(dep_wd),
    .raddr(dep_ra), .rdata(dep_raw));
  dept_ram #(.W(dept_pkg::PARW), .D(dept_pkg::NODE_CAP)) u_par (
    .clk(clk), .we(par_we), .waddr(par_wa), .wdata(par_wd),
    .raddr(par_ra), .rdata(par_rd));
  dept_ram #(.W(NW), .D(dept_pkg::NODE_CAP * dept_pkg::ALPHABET)) u_child (
    .clk(clk), .we(child_we), .waddr(child_wa), .wdata(child_wd),
    .raddr(child_ra), .rdata(child_rd));

  // The two roots are never written; their fields come from constants.
  always_comb begin
    if (node_ra_r == '0) begin
      nd_len  = '0;
      nd_link = NW'(1);
    end else if (node_ra_r == NW'(1)) begin
      nd_len  = '1;
      nd_link = '0;
    end else begin
      nd_len  = node_raw[dept_pkg::NDW-1 -: PW];
      nd_link = node_raw[NW-1:0];
    end
    dep_rd = (dep_ra_r < NW'(2)) ? '0 : dep_raw;
  end

  assign cnt      = back_r - front_r + PW'(1);
  assign guard_c  = (child_rd < NW'(dept_pkg::NODE_CAP)) ? child_rd : '0;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_end_palindromes      = o_end_r;
  assign out_distinct_palindromes = o_dist_r;
  assign out_running_total        = o_tot_r;
  assign out_overflow             = o_ovf_r;

  always_comb begin
    if (at_back_r) begin
      ps = $signed({2'b00, back_r}) - (PW+2)'(nd_len) - (PW+2)'(1);
    end else begin
      ps = $signed({2'b00, front_r}) + (PW+2)'(nd_len) + (PW+2)'(1);
    end
    inspan = (ps >= $signed({2'b00, front_r})) && (ps <= $signed({2'b00, back_r}));
  end

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    fnode_nxt    = fnode_r;
    bnode_nxt    = bnode_r;
    ntot_nxt     = ntot_r;
    sum_nxt      = sum_r;
    at_back_nxt  = at_back_r;
    phase_nxt    = phase_r;
    sym_nxt      = sym_r;
    x_nxt        = x_r;
    cur_nxt      = cur_r;
    cur_link_nxt = cur_link_r;
    link_nxt     = link_r;
    c_nxt        = c_r;
    len_nxt      = len_r;
    cur_len_nxt  = cur_len_r;
    fin_len_nxt  = fin_len_r;
    fin_dep_nxt  = fin_dep_r;
    idx_nxt      = idx_r;
    o_end_nxt    = o_end_r;
    o_dist_nxt   = o_dist_r;
    o_tot_nxt    = o_tot_r;
    o_ovf_nxt    = o_ovf_r;
    sym_we   = 1'b0;
    sym_wa   = '0;
    sym_ra   = '0;
    node_we  = 1'b0;
    node_wa  = '0;
    node_wd  = '0;
    node_ra  = '0;
    dep_we   = 1'b0;
    dep_wa   = '0;
    dep_wd   = '0;
    dep_ra   = '0;
    par_we   = 1'b0;
    par_wa   = '0;
    par_wd   = '0;
    par_ra   = '0;
    child_we = 1'b0;
    child_wa = '0;
    child_wd = '0;
    child_ra = '0;
    c_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if ((in_symbol >= 5'(dept_pkg::ALPHABET)) ||
              (cnt >= PW'(dept_pkg::MAX_SYMBOLS))) begin
            o_end_nxt  = '0;
            o_dist_nxt = 17'(ntot_r - NW'(2));
            o_tot_nxt  = sum_r;
            o_ovf_nxt  = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            sym_we      = 1'b1;
            at_back_nxt = in_action;
            sym_nxt     = in_symbol;
            phase_nxt   = 1'b0;
            if (in_action) begin
              back_nxt = back_r + PW'(1);
              sym_wa   = back_r + PW'(1);
              x_nxt    = bnode_r;
            end else begin
              front_nxt = front_r - PW'(1);
              sym_wa    = front_r - PW'(1);
              x_nxt     = fnode_r;
            end
            state_nxt = S_WRD;
          end
        end
      end
      S_WRD: begin
        node_ra   = x_r;
        state_nxt = S_WLEN;
      end
      S_WLEN: begin
        link_nxt = nd_link;
        len_nxt  = nd_len;
        if (inspan) begin
          sym_ra    = ps[PW-1:0];
          state_nxt = S_WCMP;
        end else begin
          x_nxt     = nd_link;
          state_nxt = S_WRD;
        end
      end
      S_WCMP: begin
        if (sym_rd == sym_r) begin
          child_ra = dept_pkg::child_index(x_r, sym_r);
          if (!phase_r) begin
            cur_nxt      = x_r;
            cur_len_nxt  = len_r;
            cur_link_nxt = link_r;
            idx_nxt      = dept_pkg::child_index(x_r, sym_r);
            state_nxt    = S_CRD;
          end else begin
            state_nxt = S_LRD;
          end
        end else begin
          x_nxt     = link_r;
          state_nxt = S_WRD;
        end
      end
      S_CRD: begin
        c_nxt     = child_rd;
        par_ra    = guard_c;
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        c_valid = (c_r >= NW'(2)) && (c_r < ntot_r) && (par_rd == {cur_r, sym_r});
        if (c_valid) begin
          cur_nxt   = c_r;
          state_nxt = S_FRD;
        end else if (ntot_r < NW'(dept_pkg::NODE_CAP)) begin
          x_nxt     = cur_link_r;
          phase_nxt = 1'b1;
          state_nxt = S_WRD;
        end else begin
          cur_nxt   = '0;
          state_nxt = S_FRD;
        end
      end
      S_LRD: begin
        c_nxt     = child_rd;
        par_ra    = guard_c;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        c_valid = (c_r >= NW'(2)) && (c_r < ntot_r) && (par_rd == {x_r, sym_r});
        if (c_valid) begin
          c_nxt  = c_r;
          dep_ra = c_r;
        end else begin
          c_nxt  = '0;
          dep_ra = '0;
        end
        state_nxt = S_LDEP;
      end
      S_LDEP: begin
        node_we     = 1'b1;
        node_wa     = ntot_r;
        node_wd     = {cur_len_r + PW'(2), c_r};
        dep_we      = 1'b1;
        dep_wa      = ntot_r;
        dep_wd      = dep_rd + NW'(1);
        par_we      = 1'b1;
        par_wa      = ntot_r;
        par_wd      = {cur_r, sym_r};
        child_we    = 1'b1;
        child_wa    = idx_r;
        child_wd    = ntot_r;
        cur_nxt     = ntot_r;
        ntot_nxt    = ntot_r + NW'(1);
        fin_len_nxt = cur_len_r + PW'(2);
        fin_dep_nxt = dep_rd + NW'(1);
        state_nxt   = S_FIN;
      end
      S_FRD: begin
        node_ra   = cur_r;
        dep_ra    = cur_r;
        state_nxt = S_FGET;
      end
      S_FGET: begin
        fin_len_nxt = nd_len;
        fin_dep_nxt = dep_rd;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (at_back_r) begin
          bnode_nxt = cur_r;
        end else begin
          fnode_nxt = cur_r;
        end
        if ($signed({fin_len_r[PW-1], fin_len_r}) == $signed({1'b0, cnt})) begin
          bnode_nxt = cur_r;
          fnode_nxt = cur_r;
        end
        sum_nxt    = sum_r + 32'(fin_dep_r);
        o_end_nxt  = 17'(fin_dep_r);
        o_dist_nxt = 17'(ntot_r - NW'(2));
        o_tot_nxt  = sum_r + 32'(fin_dep_r);
        o_ovf_nxt  = 1'b0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= PW'(dept_pkg::MIDDLE);
      back_r  <= PW'(dept_pkg::MIDDLE - 1);
      fnode_r <= '0;
      bnode_r <= '0;
      ntot_r  <= NW'(2);
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      fnode_r <= fnode_nxt;
      bnode_r <= bnode_nxt;
      ntot_r  <= ntot_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    at_back_r  <= at_back_nxt;
    phase_r    <= phase_nxt;
    sym_r      <= sym_nxt;
    x_r        <= x_nxt;
    cur_r      <= cur_nxt;
    cur_link_r <= cur_link_nxt;
    link_r     <= link_nxt;
    c_r        <= c_nxt;
    len_r      <= len_nxt;
    cur_len_r  <= cur_len_nxt;
    fin_len_r  <= fin_len_nxt;
    fin_dep_r  <= fin_dep_nxt;
    idx_r      <= idx_nxt;
    o_end_r    <= o_end_nxt;
    o_dist_r   <= o_dist_nxt;
    o_tot_r    <= o_tot_nxt;
    o_ovf_r    <= o_ovf_nxt;
    node_ra_r  <= node_ra;
    dep_ra_r   <= dep_ra;
  end

  a_ntot_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ntot_r >= NW'(2))
    else $error("node count fell below the two roots");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_valid && !out_overflow)
    else $error("finished item did not produce a result");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    cnt <= PW'(dept_pkg::MAX_SYMBOLS))
    else $error("stored span exceeds capacity");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_end_palindromes == '0))
    else $error("rejected item reports palindromes");

endmodule

[hw/rtl/dept_ram.sv]
module dept_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/palindrome_checker.sv]
module palindrome_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [4:0]  in_symbol,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [16:0] out_end_palindromes,
  input  logic [16:0] out_distinct_palindromes,
  input  logic [31:0] out_running_total,
  input  logic        out_overflow,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [16:0] end_pal;
    logic [16:0] distinct;
    logic [31:0] total;
    logic        ovf;
  } tree_result_t;

  tree_result_t result_q[$];

  logic [4:0] letters[int];
  int         lo_pos;
  int         hi_pos;
  int         pal_len[int];
  int         pal_link[int];
  int         pal_depth[int];
  int         child_of[longint];
  int         lo_node;
  int         hi_node;
  int         node_count;
  longint     sum_all;

  function automatic void clear_tree();
    letters.delete();
    pal_len.delete();
    pal_link.delete();
    pal_depth.delete();
    child_of.delete();
    lo_pos = dept_pkg::MIDDLE;
    hi_pos = dept_pkg::MIDDLE - 1;
    pal_len[0] = 0;
    pal_len[1] = -1;
    pal_link[0] = 1;
    pal_link[1] = 0;
    pal_depth[0] = 0;
    pal_depth[1] = 0;
    lo_node = 0;
    hi_node = 0;
    node_count = 2;
    sum_all = 0;
  endfunction

  function automatic int child_get(int n, int s);
    longint k;
    k = longint'(n) * dept_pkg::ALPHABET + s;
    return child_of.exists(k) ? child_of[k] : 0;
  endfunction

  function automatic int extendable(int x, bit at_back);
    int p;
    forever begin
      if (at_back) begin
        p = hi_pos - pal_len[x] - 1;
        if (p >= lo_pos && p <= hi_pos && letters[p] == letters[hi_pos]) return x;
      end else begin
        p = lo_pos + pal_len[x] + 1;
        if (p <= hi_pos && p >= lo_pos && letters[p] == letters[lo_pos]) return x;
      end
      x = pal_link[x];
    end
  endfunction

  function automatic tree_result_t add_letter(bit at_back, int s);
    tree_result_t r;
    int cur, u, lnk;
    r.end_pal = '0;
    r.ovf = 1'b1;
    if (s < dept_pkg::ALPHABET && hi_pos - lo_pos + 1 < dept_pkg::MAX_SYMBOLS) begin
      if (at_back) begin
        hi_pos++;
        letters[hi_pos] = 5'(s);
        cur = extendable(hi_node, 1);
      end else begin
        lo_pos--;
        letters[lo_pos] = 5'(s);
        cur = extendable(lo_node, 0);
      end
      if (child_get(cur, s) == 0 && node_count < dept_pkg::NODE_CAP) begin
        u = node_count++;
        lnk = child_get(extendable(pal_link[cur], at_back), s);
        pal_len[u] = pal_len[cur] + 2;
        pal_link[u] = lnk;
        pal_depth[u] = pal_depth[lnk] + 1;
        child_of[longint'(cur) * dept_pkg::ALPHABET + s] = u;
      end
      cur = child_get(cur, s);
      if (at_back) hi_node = cur;
      else lo_node = cur;
      if (pal_len[cur] == hi_pos - lo_pos + 1) begin
        lo_node = cur;
        hi_node = cur;
      end
      sum_all += pal_depth[cur];
      r.end_pal = 17'(pal_depth[cur]);
      r.ovf = 1'b0;
    end
    r.distinct = 17'(node_count - 2);
    r.total = 32'(sum_all);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_tree();
  end

  always @(posedge clk) begin
    tree_result_t w;
    if (!rst_n) begin
      clear_tree();
      result_q.delete();
    end else begin
      if (in_valid && !in_stall) result_q.push_back(add_letter(in_action, in_symbol));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          w = result_q.pop_front();
          if (out_end_palindromes !== w.end_pal)
            report_mismatch("end_palindromes", out_end_palindromes, w.end_pal);
          if (out_distinct_palindromes !== w.distinct)
            report_mismatch("distinct_palindromes", out_distinct_palindromes, w.distinct);
          if (out_running_total !== w.total)
            report_mismatch("running_total", out_running_total, w.total);
          if (out_overflow !== w.ovf)
            report_mismatch("overflow", out_overflow, w.ovf);
        end
      end
    end
    pending_count = result_q.size();
  end
endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [4:0]  in_symbol = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [16:0] out_end_palindromes;
  logic [16:0] out_distinct_palindromes;
  logic [31:0] out_running_total;
  logic        out_overflow;
  int          fail_count;
  int          pending_count;
  bit          calm = 1'b0;

  always #4 clk = ~clk;

  double_ended_palindrome_tree_core dut (.*);
  palindrome_checker checker_i (.*);

  always @(posedge clk) begin
    out_stall <= !calm && $urandom_range(99) < 11;
  end

  task automatic send_letter(bit act, logic [4:0] s);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_symbol <= s;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    #20_000_000;
    $display("double_ended_palindrome_tree_core verification failed");
    $finish;
  end

  initial begin
    int k, mode, pick;
    bit act;
    logic [4:0] s;
    logic [4:0] motif[$];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_letter(1'b1, 5'd0);
    send_letter(1'b0, 5'd0);
    send_letter(1'b1, 5'd25);
    send_letter(1'b0, 5'd25);
    send_letter(1'b1, 5'd26);
    send_letter(1'b0, 5'd31);
    send_letter(1'b1, 5'd0);
    send_letter(1'b0, 5'd0);
    send_letter(1'b1, 5'd1);
    send_letter(1'b0, 5'd1);
    send_letter(1'b1, 5'd30);
    for (k = 0; k < 6; k++) send_letter(k[0], 5'd7);
    send_letter(1'b1, 5'd16);
    send_letter(1'b0, 5'd8);
    k = 0;
    while (k < 1800) begin
      calm = (k >= 800 && k < 1100);
      mode = $urandom_range(9);
      if (mode < 6) begin
        motif.delete();
        repeat ($urandom_range(1, 4)) motif.push_back(5'($urandom_range(2)));
        repeat ($urandom_range(2, 12)) begin
          pick = $urandom_range(motif.size() - 1);
          send_letter(1'($urandom_range(1)), motif[pick]);
          k++;
        end
      end else if (mode < 9) begin
        act = 1'($urandom_range(1));
        s = 5'($urandom_range(25));
        send_letter(act, s);
        send_letter(act, s);
        send_letter(!act, s);
        k += 3;
      end else begin
        s = 5'($urandom);
        send_letter(1'($urandom_range(1)), s);
        k++;
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("double_ended_palindrome_tree_core verification clean");
    end else begin
      $display("double_ended_palindrome_tree_core verification failed");
    end
    $finish;
  end
endmodule
